/* hdl/rgb_kernel3x3_filter_top_defines.svh */
// Assertion macros for the RGB 3x3 kernel filter.
// Used by rgb_kernel3x3_filter_top.sv; expects clk and rst_n in the using scope.
`ifndef RGB_KERNEL3X3_FILTER_TOP_DEFINES_SVH
`define RGB_KERNEL3X3_FILTER_TOP_DEFINES_SVH

// Checks that cons holds in the same cycle as ante.
`define RKF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante.
`define RKF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/rkf_pkg.sv */
// Types, codes and arithmetic helpers of the RGB 3x3 kernel filter.
// No dependencies; imported by rgb_kernel3x3_filter_top.
package rkf_pkg;

  // Packed RGB pixel: red in [7:0], green in [15:8], blue in [23:16].
  typedef logic [23:0] rkf_pix_t;

  typedef struct packed {
    logic filt;
    logic last;
  } rkf_ctl_t;

  typedef struct packed {
    logic     last;
    rkf_pix_t pix;
  } rkf_word_t;

  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_KERNEL_MODE  = 2'd2;

  localparam logic [2:0] MODE_SMOOTH  = 3'd0;
  localparam logic [2:0] MODE_BLUR    = 3'd1;
  localparam logic [2:0] MODE_SHARPEN = 3'd2;
  localparam logic [2:0] MODE_MEAN    = 3'd3;
  localparam logic [2:0] MODE_EMBOSS  = 3'd4;

  localparam int CFG_WIDTH_RESET  = 640;
  localparam int CFG_HEIGHT_RESET = 480;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_CW    = FIFO_AW + 1;

  // Rounded-up reciprocals scaled by 2^16; exact for the sum ranges seen here.
  localparam logic [14:0] RECIP_9 = 15'd7282;
  localparam logic [14:0] RECIP_3 = 15'd21846;

  // Kernel numerator for one channel; nb holds window entry k in bits [8k+7:8k].
  function automatic logic signed [12:0] rkf_kernel_sum(input logic [71:0] nb,
                                                        input logic [2:0]  mode);
    logic signed [12:0] ctr;
    logic signed [12:0] edg;
    logic signed [12:0] crn;
    logic signed [12:0] all;
    logic signed [12:0] res;
    ctr = 13'(nb[39:32]);
    edg = 13'(nb[15:8]) + 13'(nb[31:24]) + 13'(nb[47:40]) + 13'(nb[63:56]);
    crn = 13'(nb[7:0]) + 13'(nb[23:16]) + 13'(nb[55:48]) + 13'(nb[71:64]);
    all = ctr + edg + crn;
    unique case (mode)
      MODE_SMOOTH:  res = all;
      MODE_BLUR:    res = all + edg + 13'sd3 * ctr;
      MODE_SHARPEN: res = 13'sd11 * ctr - 13'sd2 * edg;
      MODE_MEAN:    res = 13'sd10 * ctr - all;
      MODE_EMBOSS:  res = 13'(nb[15:8]) - 13'(nb[63:56]);
      default:      res = '0;
    endcase
    return res;
  endfunction

  // Divides the numerator toward zero and clamps the quotient to 0..255.
  function automatic logic [7:0] rkf_scale(input logic signed [12:0] s,
                                           input logic [2:0]         mode);
    logic [11:0] u;
    logic [14:0] recip;
    logic [26:0] prod;
    logic [11:0] q;
    logic [7:0]  res;
    u     = s[11:0];
    recip = (mode == MODE_SMOOTH) ? RECIP_9 : RECIP_3;
    prod  = u * recip;
    unique case (mode)
      MODE_SMOOTH, MODE_SHARPEN: q = {1'b0, prod[26:16]};
      MODE_BLUR:                 q = {4'b0, u[11:4]};
      default:                   q = u;
    endcase
    if (s < 0) begin
      res = '0;
    end else if (q > 12'd255) begin
      res = 8'hFF;
    end else begin
      res = q[7:0];
    end
    return res;
  endfunction

endpackage

/* hdl/rgb_kernel3x3_filter_top.sv */
// RGB 3x3 kernel filter: two line-store memories, a 3x3 window and an output queue.
// Depends on rkf_pkg and rgb_kernel3x3_filter_top_defines.svh.
//
// Usage: pixels arrive in raster order on the in_ stream, one word per pixel, with
// in_tuser low. A word with in_tuser high is a drain: it releases the oldest pending
// result, always unfiltered. A frame's last row is pushed out by drains or by the
// first pixels of the next frame. Each result leaves on the out_ stream; out_tlast
// marks the final pixel of a frame.
// Throughput is one word per clock while in_tready is high. A released result passes
// the line-store read, the window update, the kernel adders and the reciprocal
// multiply and clamp, in that order, before it reaches the output queue. A centre
// result follows the pixel below and to the right of it, so results lag the stream by
// frame_width + 1 pixels.
// When the receiver stalls, results collect in an eight-word queue; in_tready drops
// once the queue could not hold a new word as well as every word in the pipeline.
// Reset clears the counters, the window and the queue and loads width 640, height 480
// and the smooth kernel. The line stores are not cleared: every entry that feeds an
// emitted result has been written first. Writing width or height starts a new frame.
// The user must write configuration only while the block is idle; it is not enforced.
`include "rgb_kernel3x3_filter_top_defines.svh"

module rgb_kernel3x3_filter_top
  import rkf_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // in_red [7:0], in_green [15:8], in_blue [23:16]
  input  logic        in_tuser,   // req_type: 0 pixel, 1 drain
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_red [7:0], out_green [15:8], out_blue [23:16]
  output logic        out_tlast,  // frame_last
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [12:0] cfg_wdata
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int PW    = $clog2(MAX_WIDTH + 2);
  localparam int AH    = $clog2(MAX_HEIGHT);
  localparam int RST_W = (CFG_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : CFG_WIDTH_RESET;
  localparam int RST_H = (CFG_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : CFG_HEIGHT_RESET;

  // Configuration, stored already clamped.
  logic [WW-1:0] w_r;
  logic [AW-1:0] wm1_r;
  logic [AH-1:0] hm1_r;
  logic [2:0]    kernel_mode_r;
  int            wclamp;
  int            hclamp;
  logic          restart;

  // Stream position and the count of pixels accepted but not yet emitted.
  logic [AW-1:0] in_col_r,  in_col_nxt;
  logic [AW-1:0] out_col_r, out_col_nxt;
  logic [AH-1:0] out_row_r, out_row_nxt;
  logic [PW-1:0] pend_r,    pend_nxt;

  logic          in_acc;
  logic          pend_zero;
  logic          pend_full;
  logic          pend_above_w;
  logic          emit_c;
  logic          interior;
  logic [AW-1:0] rd_addr;
  rkf_ctl_t      ctl_c;

  // Line stores.
  rkf_pix_t      up_mem  [MAX_WIDTH];
  rkf_pix_t      mid_mem [MAX_WIDTH];
  rkf_pix_t      up_rdata_r;
  rkf_pix_t      mid_rdata_r;
  logic          up_we;

  // Read stage: memory data valid.
  logic          s2_valid_r;
  logic          s2_pixel_r;
  logic          s2_emit_r;
  logic          s2_src_up_r;
  rkf_ctl_t      s2_ctl_r;
  logic [AW-1:0] s2_addr_r;
  rkf_pix_t      s2_px_r;
  logic          s2_fwd_r;
  rkf_pix_t      s2_fwd_data_r;
  rkf_pix_t      top_px;

  // Window and the two arithmetic stages.
  rkf_pix_t           win_r [9];
  logic               s3_valid_r;
  rkf_ctl_t           s3_ctl_r;
  rkf_pix_t           s3_pass_r;
  logic signed [12:0] sum_c [3];
  logic               s4_valid_r;
  rkf_ctl_t           s4_ctl_r;
  rkf_pix_t           s4_pass_r;
  logic signed [12:0] s4_sum_r [3];
  rkf_pix_t           scaled_c;
  rkf_word_t          push_word;

  // Output queue.
  rkf_word_t          fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_CW-1:0] fifo_cnt_r;
  logic [FIFO_CW-1:0] inflight;
  logic               pop;

  // ---------------------------------------------------------------------------
  // Configuration.
  // ---------------------------------------------------------------------------
  always_comb begin
    wclamp = int'(cfg_wdata[11:0]);
    if (wclamp < 3) begin
      wclamp = 3;
    end else if (wclamp > MAX_WIDTH) begin
      wclamp = MAX_WIDTH;
    end
    hclamp = int'(cfg_wdata[12:0]);
    if (hclamp < 3) begin
      hclamp = 3;
    end else if (hclamp > MAX_HEIGHT) begin
      hclamp = MAX_HEIGHT;
    end
  end

  assign restart = cfg_we && (cfg_idx == CFG_FRAME_WIDTH || cfg_idx == CFG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r           <= WW'(RST_W);
      wm1_r         <= AW'(RST_W - 1);
      hm1_r         <= AH'(RST_H - 1);
      kernel_mode_r <= MODE_SMOOTH;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_FRAME_WIDTH: begin
          w_r   <= WW'(wclamp);
          wm1_r <= AW'(wclamp - 1);
        end
        CFG_FRAME_HEIGHT: hm1_r <= AH'(hclamp - 1);
        CFG_KERNEL_MODE:  kernel_mode_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Accept stage: all position bookkeeping is settled here, before memory data
  // returns, so the next word can be taken in the following cycle.
  // ---------------------------------------------------------------------------
  assign in_acc       = in_tvalid && in_tready;
  assign pend_zero    = (pend_r == '0);
  assign pend_full    = (pend_r == PW'(w_r) + PW'(1));
  assign pend_above_w = (pend_r > PW'(w_r));
  assign interior     = (out_col_r != '0) && (out_col_r != wm1_r) &&
                        (out_row_r != '0) && (out_row_r != hm1_r);

  always_comb begin
    emit_c      = in_tuser ? !pend_zero : pend_full;
    rd_addr     = in_tuser ? out_col_r : in_col_r;
    ctl_c.filt  = !in_tuser && interior && (kernel_mode_r <= MODE_EMBOSS);
    ctl_c.last  = (out_col_r == wm1_r) && (out_row_r == hm1_r);

    in_col_nxt  = in_col_r;
    if (!in_tuser) begin
      in_col_nxt = (in_col_r == wm1_r) ? '0 : in_col_r + AW'(1);
    end

    pend_nxt = pend_r;
    if (in_tuser && !pend_zero) begin
      pend_nxt = pend_r - PW'(1);
    end else if (!in_tuser && !pend_full) begin
      pend_nxt = pend_r + PW'(1);
    end

    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (emit_c) begin
      if (out_col_r == wm1_r) begin
        out_col_nxt = '0;
        out_row_nxt = (out_row_r == hm1_r) ? '0 : out_row_r + AH'(1);
      end else begin
        out_col_nxt = out_col_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      in_col_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      pend_r    <= '0;
    end else if (in_acc) begin
      in_col_r  <= in_col_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      pend_r    <= pend_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores. The middle store takes the new pixel at the accept edge and returns
  // the old entry in the same access. The upper store takes the old middle entry in the
  // following cycle; a read of that same entry at that edge is served from a bypass.
  // ---------------------------------------------------------------------------
  assign up_we = s2_valid_r && s2_pixel_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mid_rdata_r <= mid_mem[rd_addr];
    end
    if (in_acc && !in_tuser) begin
      mid_mem[in_col_r] <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      up_rdata_r <= up_mem[rd_addr];
    end
    if (up_we) begin
      up_mem[s2_addr_r] <= mid_rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= in_acc && (!in_tuser || emit_c);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s2_pixel_r    <= !in_tuser;
      s2_emit_r     <= emit_c;
      s2_src_up_r   <= pend_above_w;
      s2_ctl_r      <= ctl_c;
      s2_addr_r     <= rd_addr;
      s2_px_r       <= in_tdata;
      s2_fwd_r      <= up_we && (s2_addr_r == rd_addr);
      s2_fwd_data_r <= mid_rdata_r;
    end
  end

  assign top_px = s2_fwd_r ? s2_fwd_data_r : up_rdata_r;

  // ---------------------------------------------------------------------------
  // Window: columns shift left and the new column enters on the right.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= '0;
      end
    end else if (up_we) begin
      for (int r = 0; r < 3; r++) begin
        win_r[3 * r]     <= win_r[3 * r + 1];
        win_r[3 * r + 1] <= win_r[3 * r + 2];
      end
      win_r[2] <= top_px;
      win_r[5] <= mid_rdata_r;
      win_r[8] <= s2_px_r;
    end
  end

  // A pixel's unfiltered result is the entry that becomes the window centre; a
  // drain's is the stored pixel it read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r && s2_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_ctl_r  <= s2_ctl_r;
    s3_pass_r <= s2_pixel_r ? win_r[5] : (s2_src_up_r ? top_px : mid_rdata_r);
  end

  // ---------------------------------------------------------------------------
  // Kernel numerators from the updated window, then scaling and clamping.
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [71:0] nb;
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) begin
        nb[8 * k +: 8] = win_r[k][8 * ch +: 8];
      end
      sum_c[ch] = rkf_kernel_sum(nb, kernel_mode_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_ctl_r  <= s3_ctl_r;
    s4_pass_r <= s3_pass_r;
    for (int ch = 0; ch < 3; ch++) begin
      s4_sum_r[ch] <= sum_c[ch];
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      scaled_c[8 * ch +: 8] = rkf_scale(s4_sum_r[ch], kernel_mode_r);
    end
    push_word.last = s4_ctl_r.last;
    push_word.pix  = s4_ctl_r.filt ? scaled_c : s4_pass_r;
  end

  // ---------------------------------------------------------------------------
  // Output queue. A word is taken only if the queue can absorb every word still
  // travelling through the pipeline, so the pipeline itself never stalls.
  // ---------------------------------------------------------------------------
  assign pop        = out_tvalid && out_tready;
  assign inflight   = FIFO_CW'(s2_valid_r && s2_emit_r) + FIFO_CW'(s3_valid_r) +
                      FIFO_CW'(s4_valid_r);
  assign in_tready  = (fifo_cnt_r + inflight) < FIFO_CW'(FIFO_DEPTH);
  assign out_tvalid = (fifo_cnt_r != '0);
  assign out_tdata  = fifo_mem[rd_ptr_r].pix;
  assign out_tlast  = fifo_mem[rd_ptr_r].last;

  always_ff @(posedge clk) begin
    if (s4_valid_r) begin
      fifo_mem[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (s4_valid_r) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + FIFO_CW'(s4_valid_r) - FIFO_CW'(pop);
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `RKF_ASSERT_NOW(a_fifo_room, s4_valid_r, (fifo_cnt_r < FIFO_CW'(FIFO_DEPTH)) || pop, "output queue overflow")
  `RKF_ASSERT_NEXT(a_pend_bound, in_acc, pend_r <= PW'(w_r) + PW'(1), "pending count above width plus one")
  `RKF_ASSERT_NEXT(a_col_bound, in_acc, (in_col_r <= wm1_r) && (out_col_r <= wm1_r), "column beyond frame width")

endmodule

/* verif/tb_rgb_kernel3x3_filter_top.sv */
// Self-checking testbench for rgb_kernel3x3_filter_top: a directed and random pixel stream,
// checked word by word against a line-store and window predictor built into this file.
// Depends on rkf_pkg and the RTL of rgb_kernel3x3_filter_top; reads no files.
module tb_rgb_kernel3x3_filter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rkf_pkg::*;

  // Geometry of the instance; the predictor keeps line stores of the same depth.
  localparam int LINE_DEPTH = 2048;
  localparam int ROWS_MAX   = 4096;
  localparam int SIDE_MIN   = 3;

  // Codes that the package does not name.
  localparam logic       REQ_PIXEL      = 1'b0;
  localparam logic       REQ_DRAIN      = 1'b1;
  localparam logic [1:0] CFG_SPARE      = 2'd3;  // unused register index, writes are ignored
  localparam logic [2:0] MODE_CODE_TOP  = 3'd7;  // highest mode code, passes pixels through

  // Run control.
  localparam int CYCLE_LIMIT = 3000000;
  localparam int RESULT_WAIT = 5000;
  localparam int PIPE_PAUSE  = 16;
  localparam int RANDOM_ITEMS = 480;

  localparam logic [23:0] BLACK     = 24'h000000;
  localparam logic [23:0] WHITE     = 24'hFFFFFF;
  localparam logic [23:0] GREEN_HI  = 24'h80FF00;  // blue 0x80, green 0xFF, red 0x00
  localparam logic [23:0] RED_HI    = 24'h8000FF;  // blue 0x80, green 0x00, red 0xFF

  // One word of the input stream.
  typedef struct packed {
    logic        kind;
    logic [23:0] rgb;
  } feed_word_t;

  // One result word; the layout matches {out_tlast, out_tdata}.
  typedef struct packed {
    logic       last;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic        in_tuser   = REQ_PIXEL;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_idx    = CFG_FRAME_WIDTH;
  logic [12:0] cfg_wdata  = '0;

  // Words waiting to be sent, and the results that the predictor says must come back.
  feed_word_t  pixel_feed[$];
  pix_result_t predicted_pixels[$];

  int          fail_count  = 0;
  int          cycle_count = 0;
  int          src_gap     = 0;
  int          sink_gap    = 0;
  bit          stall_src   = 1'b0;
  bit          stall_sink  = 1'b0;

  // Predictor state: its own copy of the registers, line stores, window and counters.
  logic [11:0] width_reg;
  logic [12:0] height_reg;
  logic [2:0]  mode_reg;
  logic [23:0] upper_line  [LINE_DEPTH];
  logic [23:0] middle_line [LINE_DEPTH];
  logic [23:0] win [9];
  int unsigned in_col, in_row, out_col, out_row, backlog;

  rgb_kernel3x3_filter_top #(
    .MAX_WIDTH  (LINE_DEPTH),
    .MAX_HEIGHT (ROWS_MAX)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // in_red [7:0], in_green [15:8], in_blue [23:16]
    .in_tuser   (in_tuser),   // req_type
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // out_red [7:0], out_green [15:8], out_blue [23:16]
    .out_tlast  (out_tlast),  // frame_last
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  // The registers are used clamped to SIDE_MIN and to the line-store depth or ROWS_MAX.
  function automatic int unsigned eff_width();
    if (width_reg < SIDE_MIN) return SIDE_MIN;
    if (width_reg > LINE_DEPTH) return LINE_DEPTH;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg < SIDE_MIN) return SIDE_MIN;
    if (height_reg > ROWS_MAX) return ROWS_MAX;
    return height_reg;
  endfunction

  // A new frame starts from column and row zero with an empty window; line stores keep data.
  function automatic void restart_frame();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
    backlog = 0;
    for (int k = 0; k < 9; k++) win[k] = '0;
  endfunction

  // Weight of window position k, numbered in raster order with the centre at 4.
  function automatic int tap_weight(input logic [2:0] mode, input int k);
    case (mode)
      MODE_SMOOTH:  return 1;
      MODE_BLUR:    return (k == 4) ? 4 : (k % 2 == 1) ? 2 : 1;
      MODE_SHARPEN: return (k == 4) ? 11 : (k % 2 == 1) ? -2 : 0;
      MODE_MEAN:    return (k == 4) ? 9 : -1;
      default:      return (k == 1) ? 1 : (k == 7) ? -1 : 0;  // emboss: above minus below
    endcase
  endfunction

  // Kernel result for the channel at bit offset sh, truncated toward zero and clamped.
  function automatic logic [7:0] filtered_level(input int sh);
    int acc;
    int quo;
    int divisor;
    int k;
    if (mode_reg > MODE_EMBOSS) return win[4][sh +: 8];
    acc = 0;
    for (k = 0; k < 9; k++) acc += tap_weight(mode_reg, k) * int'(win[k][sh +: 8]);
    case (mode_reg)
      MODE_SMOOTH:  divisor = 9;
      MODE_BLUR:    divisor = 16;
      MODE_SHARPEN: divisor = 3;
      default:      divisor = 1;
    endcase
    quo = acc / divisor;
    if (quo < 0) return 8'd0;
    if (quo > 255) return 8'd255;
    return quo[7:0];
  endfunction

  // Builds the result for the current output position and moves that position on.
  function automatic pix_result_t emit_pixel(input logic [23:0] rgb, input int unsigned w,
                                             input int unsigned h);
    pix_result_t res;
    res.red   = rgb[7:0];
    res.green = rgb[15:8];
    res.blue  = rgb[23:16];
    res.last  = (out_col == w - 1) && (out_row == h - 1);
    if (out_col >= w - 1) begin
      out_col = 0;
      out_row = (out_row >= h - 1) ? 0 : out_row + 1;
    end else begin
      out_col++;
    end
    return res;
  endfunction

  // Applies one accepted word; returns 1 when it releases a result word.
  function automatic bit advance_filter(input logic kind, input logic [23:0] rgb,
                                        output pix_result_t res);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    logic [23:0] top;
    logic [23:0] mid;
    logic [23:0] pix;
    w = eff_width();
    h = eff_height();
    if (kind == REQ_DRAIN) begin
      if (backlog == 0) return 1'b0;
      // The oldest pending pixel is still in the upper store if a whole row came after it.
      c = (out_col >= LINE_DEPTH) ? 0 : out_col;
      pix = (backlog > w) ? upper_line[c] : middle_line[c];
      res = emit_pixel(pix, w, h);
      backlog--;
      return 1'b1;
    end
    c = (in_col >= LINE_DEPTH) ? 0 : in_col;
    top = upper_line[c];
    mid = middle_line[c];
    upper_line[c]  = mid;
    middle_line[c] = rgb;
    for (int i = 0; i < 3; i++) begin
      win[i * 3]     = win[i * 3 + 1];
      win[i * 3 + 1] = win[i * 3 + 2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = rgb;
    if (in_col >= w - 1) begin
      in_col = 0;
      in_row = (in_row >= h - 1) ? 0 : in_row + 1;
    end else begin
      in_col++;
    end
    backlog++;
    if (backlog <= w + 1) return 1'b0;
    backlog--;
    // Border positions pass the centre through; interior ones get the kernel.
    if (out_row >= 1 && out_row <= h - 2 && out_col >= 1 && out_col <= w - 2) begin
      pix = {filtered_level(16), filtered_level(8), filtered_level(0)};
    end else begin
      pix = win[4];
    end
    res = emit_pixel(pix, w, h);
    return 1'b1;
  endfunction

  function automatic void write_register(input logic [1:0] idx, input logic [12:0] val);
    case (idx)
      CFG_FRAME_WIDTH: begin
        width_reg = val[11:0];
        restart_frame();
      end
      CFG_FRAME_HEIGHT: begin
        height_reg = val;
        restart_frame();
      end
      CFG_KERNEL_MODE: mode_reg = val[2:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driver: sends words from pixel_feed, with random bursts of idle cycles when stall_src
  // is set. tvalid is only lowered after the current word has been taken.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    feed_word_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= REQ_PIXEL;
      src_gap   = 0;
    end else if (!in_tvalid || in_tready) begin
      if (src_gap != 0) begin
        src_gap--;
        in_tvalid <= 1'b0;
      end else if (stall_src && $urandom_range(0, 7) == 0) begin
        src_gap = $urandom_range(0, 8);
        in_tvalid <= 1'b0;
      end else if (pixel_feed.size() != 0) begin
        nxt = pixel_feed.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= nxt.kind;
        in_tdata  <= nxt.rgb;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: checks each result word against the oldest prediction, then feeds accepted
  // input words and register writes to the predictor, and throttles out_tready. Checking
  // and prediction share this block so that checking always runs before prediction.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    pix_result_t got;
    pix_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_gap   = 0;
      width_reg  = 12'(CFG_WIDTH_RESET);
      height_reg = 13'(CFG_HEIGHT_RESET);
      mode_reg   = MODE_SMOOTH;
      restart_frame();
      // The stores are undefined in hardware; nothing emitted ever reads an unwritten entry.
      for (int i = 0; i < LINE_DEPTH; i++) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tlast, out_tdata};
        if (predicted_pixels.size() == 0) begin
          $error("result word with nothing expected: tdata %h, tlast %b", out_tdata, out_tlast);
          fail_count++;
        end else begin
          want = predicted_pixels.pop_front();
          if (got.red !== want.red) begin
            $error("out_red: expected %0d, actual %0d", want.red, got.red);
            fail_count++;
          end
          if (got.green !== want.green) begin
            $error("out_green: expected %0d, actual %0d", want.green, got.green);
            fail_count++;
          end
          if (got.blue !== want.blue) begin
            $error("out_blue: expected %0d, actual %0d", want.blue, got.blue);
            fail_count++;
          end
          if (got.last !== want.last) begin
            $error("frame_last: expected %0b, actual %0b", want.last, got.last);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready && advance_filter(in_tuser, in_tdata, want)) begin
        predicted_pixels.push_back(want);
      end
      if (cfg_we) write_register(cfg_idx, cfg_wdata);
      if (sink_gap != 0) begin
        sink_gap--;
        out_tready <= 1'b0;
      end else if (stall_sink && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 8);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------

  // Channel levels lean toward the extremes so the clamps are hit often.
  function automatic logic [7:0] rand_level();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_pixel(input logic [23:0] rgb);
    pixel_feed.push_back('{kind: REQ_PIXEL, rgb: rgb});
  endtask

  // Drain words carry random data that the block must ignore.
  task automatic queue_drains(input int n);
    for (int i = 0; i < n; i++) pixel_feed.push_back('{kind: REQ_DRAIN, rgb: 24'($urandom)});
  endtask

  // With ragged set, drains are scattered in mid-frame.
  task automatic queue_random_pixels(input int n, input bit ragged);
    for (int i = 0; i < n; i++) begin
      if (ragged && $urandom_range(0, 11) == 0) queue_drains(1);
      queue_pixel({rand_level(), rand_level(), rand_level()});
    end
  endtask

  // One register write; the predictor picks it up at the edge where cfg_we is high.
  task automatic cfg_write(input logic [1:0] idx, input logic [12:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Waits until every queued word is sent and every predicted word has come back. Words
  // that release nothing may still be in the pipeline then, so a pause follows on request.
  task automatic settle(input bit pause);
    int n;
    while (pixel_feed.size() != 0 || in_tvalid) @(negedge clk);
    n = 0;
    while (predicted_pixels.size() != 0 && n < RESULT_WAIT) begin
      @(negedge clk);
      n++;
    end
    if (predicted_pixels.size() != 0) begin
      $error("%0d expected result words never arrived", predicted_pixels.size());
      fail_count++;
      predicted_pixels.delete();
    end
    if (pause) repeat (PIPE_PAUSE) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------------------
  initial begin : stimulus
    int w;
    int h;
    int n;
    int half;
    int useful;
    bit ragged;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    stall_src  = 1'b1;
    stall_sink = 1'b1;

    // Smallest frame, sizes written below the minimum. A drain with nothing pending
    // comes first. The 3x3 frame puts a bright red centre between green-heavy edges, so
    // sharpen saturates red high and green low while blue stays in range.
    cfg_write(CFG_FRAME_WIDTH, 13'd2);
    cfg_write(CFG_FRAME_HEIGHT, 13'd1);
    cfg_write(CFG_KERNEL_MODE, 13'(MODE_SHARPEN));
    queue_drains(1);
    queue_pixel(WHITE);
    queue_pixel(GREEN_HI);
    queue_pixel(WHITE);
    queue_pixel(GREEN_HI);
    queue_pixel(RED_HI);
    queue_pixel(GREEN_HI);
    queue_pixel(WHITE);
    queue_pixel(GREEN_HI);
    queue_pixel(BLACK);
    // Four pixels are still pending; the fifth drain finds none.
    queue_drains(5);
    settle(1);

    // Drains in mid-frame release pixels unfiltered, under the highest mode code.
    cfg_write(CFG_KERNEL_MODE, 13'(MODE_CODE_TOP));
    queue_pixel(BLACK);
    queue_pixel(WHITE);
    queue_drains(3);
    settle(1);

    // Widest line: a width past the maximum is clamped to the line-store depth. A short
    // ragged run stays within the lag, so the drains release every pixel unfiltered.
    cfg_write(CFG_FRAME_WIDTH, 13'd4095);
    cfg_write(CFG_FRAME_HEIGHT, 13'd3);
    cfg_write(CFG_KERNEL_MODE, 13'(MODE_BLUR));
    queue_random_pixels(24, 1'b1);
    queue_drains(26);
    settle(1);

    // Tallest frame: a height past the maximum is clamped; a narrow frame runs ten rows.
    cfg_write(CFG_FRAME_WIDTH, 13'd3);
    cfg_write(CFG_FRAME_HEIGHT, 13'd8191);
    cfg_write(CFG_KERNEL_MODE, 13'(MODE_EMBOSS));
    queue_random_pixels(10 * eff_width(), 1'b0);
    queue_drains(eff_width() + 2);
    settle(1);

    // Random phases: mostly whole frames of random content at small sizes, some ragged
    // streams with stray drains, now and then a hold until the output side is empty.
    useful = 0;
    while (useful < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       w = $urandom_range(0, 2);
        1:       w = $urandom_range(9, 40);
        default: w = $urandom_range(3, 8);
      endcase
      h = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
      stall_src  = $urandom_range(0, 3) != 0;
      stall_sink = $urandom_range(0, 3) != 0;
      cfg_write(CFG_FRAME_WIDTH, 13'(w));
      cfg_write(CFG_FRAME_HEIGHT, 13'(h));
      cfg_write(CFG_KERNEL_MODE, 13'($urandom_range(0, 7)));
      if ($urandom_range(0, 4) == 0) cfg_write(CFG_SPARE, 13'($urandom));
      w = eff_width();
      h = eff_height();
      ragged = $urandom_range(0, 3) == 0;
      n = ragged ? $urandom_range(1, 2 * w * h) : w * h * ((w > 8) ? 1 : $urandom_range(1, 3));
      useful += n + w + 1;
      if ($urandom_range(0, 3) == 0) begin
        half = n / 2;
        queue_random_pixels(half, ragged);
        settle(1'b0);
        n -= half;
      end
      queue_random_pixels(n, ragged);
      queue_drains(w + 1 + $urandom_range(0, 2));
      settle(1);
    end

    // Closing stretch at full rate on both sides.
    stall_src  = 1'b0;
    stall_sink = 1'b0;
    cfg_write(CFG_FRAME_WIDTH, 13'd5);
    cfg_write(CFG_FRAME_HEIGHT, 13'd4);
    cfg_write(CFG_KERNEL_MODE, 13'(MODE_MEAN));
    queue_random_pixels(2 * eff_width() * eff_height(), 1'b0);
    queue_drains(eff_width() + 1);
    settle(1);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
